### sv/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

    // Width kept for each of the two length fields of the header.
    localparam int LENGTH_BITS = 32;
    // Width of a length field as it appears on the wire.
    localparam int HDR_LEN_W   = 32;

    localparam logic [3:0]  HEADER_BYTES = 4'd12;
    localparam logic [31:0] MASK_RESET   = 32'd169564;

    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_NAME    = 2'd1,
        PH_MESSAGE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        PART_NAME    = 2'd0,
        PART_MESSAGE = 2'd1,
        PART_EMPTY   = 2'd2
    } t_part;

    typedef struct packed {
        logic       valid;
        logic [7:0] command_code;
        logic       recognized;
        t_part      part;
        logic [7:0] payload_byte;
        logic       part_last;
        logic       frame_last;
    } t_result;

endpackage

### sv/lpfp_parse.sv
// ----------------------------------------------------------------------------
// lpfp_parse
// Frame position tracking and result forming, one word per cycle with i_take.
// ----------------------------------------------------------------------------
module lpfp_parse
    import lpfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_mask,
    output t_result     o_result
);

    t_phase     r_phase,        n_phase;
    logic [3:0] r_header_count, n_header_count;
    logic [7:0] r_command,      n_command;
    t_len       r_name_left,    n_name_left;
    t_len       r_message_left, n_message_left;

    logic [3:0]           hc;
    logic [3:0]           hc_next;
    logic [4:0]           lane_shift;
    logic [HDR_LEN_W-1:0] lane_word;
    t_len                 name_dec;
    t_len                 message_dec;
    t_result              res;

    assign lane_shift  = {hc[1:0], 3'b000};
    assign lane_word   = HDR_LEN_W'(i_byte) << lane_shift;
    assign name_dec    = r_name_left - t_len'(1);
    assign message_dec = r_message_left - t_len'(1);

    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_command      = r_command;
        n_name_left    = r_name_left;
        n_message_left = r_message_left;
        hc             = r_header_count;
        hc_next        = r_header_count;
        res            = '0;
        res.command_code = r_command;
        res.payload_byte = i_byte;

        case (r_phase)
            PH_NAME: begin
                n_name_left    = name_dec;
                res.valid      = 1'b1;
                res.part       = PART_NAME;
                res.part_last  = (name_dec == '0);
                res.frame_last = (name_dec == '0) && (r_message_left == '0);
                if (name_dec == '0) begin
                    n_phase = (r_message_left != '0) ? PH_MESSAGE : PH_HEADER;
                end
            end
            PH_MESSAGE: begin
                n_message_left = message_dec;
                res.valid      = 1'b1;
                res.part       = PART_MESSAGE;
                res.part_last  = (message_dec == '0);
                res.frame_last = (message_dec == '0);
                if (message_dec == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                // The unused phase code behaves as the header phase.
                n_phase = PH_HEADER;
                hc = (r_header_count >= HEADER_BYTES) ? 4'd0 : r_header_count;
                if (hc == 4'd0) begin
                    n_command      = i_byte;
                    n_name_left    = '0;
                    n_message_left = '0;
                end else if (hc inside {[4'd4:4'd7]}) begin
                    n_name_left = t_len'(HDR_LEN_W'(r_name_left) | lane_word);
                end else if (hc inside {[4'd8:4'd11]}) begin
                    n_message_left = t_len'(HDR_LEN_W'(r_message_left) | lane_word);
                end
                hc_next        = hc + 4'd1;
                n_header_count = hc_next;
                if (hc_next == HEADER_BYTES) begin
                    n_header_count = 4'd0;
                    if (n_name_left != '0) begin
                        n_phase = PH_NAME;
                    end else if (n_message_left != '0) begin
                        n_phase = PH_MESSAGE;
                    end else begin
                        // A frame with no payload still reports one marker.
                        res.valid        = 1'b1;
                        res.command_code = n_command;
                        res.part         = PART_EMPTY;
                        res.payload_byte = 8'd0;
                        res.frame_last   = 1'b1;
                    end
                end
            end
        endcase

        res.recognized = (res.command_code[7:5] == 3'd0)
                         && i_mask[res.command_code[4:0]];
        res.valid      = res.valid && i_take;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_count <= 4'd0;
            r_command      <= 8'd0;
            r_name_left    <= '0;
            r_message_left <= '0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_command      <= n_command;
            r_name_left    <= n_name_left;
            r_message_left <= n_message_left;
        end
    end

endmodule

### sv/lpfp_out.sv
// ----------------------------------------------------------------------------
// lpfp_out
// Result register that holds a word until the downstream side takes it.
// ----------------------------------------------------------------------------
module lpfp_out
    import lpfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_result.valid) begin
            r_data <= i_result;
        end
    end

    always_comb begin
        o_result       = r_data;
        o_result.valid = r_valid;
    end

endmodule

### sv/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Splits a byte stream into length-prefixed frames and tags every payload
// byte with its command, part and end marks.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Word
//  rx       in         i_rx_valid / o_rx_stall    i_rx_byte
//  res      out        o_res_valid / i_res_stall  command, flags, payload byte
//  cfg      in         i_cfg_valid / o_cfg_ready  recognized command mask
//
//  One stream word is accepted per cycle while o_rx_stall is low. A word
//  passes through the input register, is parsed, and its result is held in
//  the result register. Reset is synchronous; there is no clearing pass. A
//  result-side stall with a full result register holds the input register,
//  and the rx channel stalls only while both registers are full.
//
module length_prefixed_frame_parser
    import lpfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [7:0]  o_command_code,
    output logic        o_recognized,
    output logic [1:0]  o_part,
    output logic [7:0]  o_payload_byte,
    output logic        o_part_last,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [31:0] r_mask;
    logic        out_ready;
    logic        take;
    t_result     parse_res;
    t_result     out_res;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = r_in_valid && !out_ready;
    assign take        = r_in_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mask     <= MASK_RESET;
        end else begin
            if (!o_rx_stall) begin
                r_in_valid <= i_rx_valid;
            end
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    lpfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (r_in_byte),
        .i_mask   (r_mask),
        .o_result (parse_res)
    );

    lpfp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (parse_res),
        .i_stall  (i_res_stall),
        .o_ready  (out_ready),
        .o_result (out_res)
    );

    assign o_res_valid    = out_res.valid;
    assign o_command_code = out_res.command_code;
    assign o_recognized   = out_res.recognized;
    assign o_part         = out_res.part;
    assign o_payload_byte = out_res.payload_byte;
    assign o_part_last    = out_res.part_last;
    assign o_frame_last   = out_res.frame_last;

    // The input side only backs up when a result is waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (o_res_valid && i_res_stall))
        else $error("rx stalled without a blocked result");

    // A held input word keeps its value until it is parsed.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register changed while stalled");

    // A payload word that ends the frame also ends its part.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_last && (o_part != PART_EMPTY)) |-> o_part_last)
        else $error("frame ended on a word that does not end its part");

endmodule
